[hw/rtl/lpe_pkg.sv]
// lpe_pkg: shared types, constants and helper functions of the 3x3 Laplacian edge filter.
// Used by every module of the block except lpe_fifo; depends on nothing else.
package lpe_pkg;

   localparam int PIX_W        = 8;
   localparam int COL_OUT_W    = 10;
   localparam int ROW_W        = 16;
   localparam int SUM_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
   localparam int MIN_DIM = 3;

   // register index, taken from the word address bit of the configuration port
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [PIX_W-1:0] SAT_MAX = 8'hFF;

   // one accepted pixel after classification
   typedef struct packed {
      logic [PIX_W-1:0]     pixel;
      logic [COL_OUT_W-1:0] center_col;
      logic [ROW_W-1:0]     center_row;
      logic                 emit;
      logic                 last;
   } lpe_item_type;

   // one result transaction
   typedef struct packed {
      logic [PIX_W-1:0]     edge_four;
      logic [PIX_W-1:0]     edge_eight;
      logic [COL_OUT_W-1:0] center_col;
      logic [ROW_W-1:0]     center_row;
      logic                 frame_last;
   } lpe_result_type;

   function automatic logic signed [SUM_W-1:0] ext_pix(input logic [PIX_W-1:0] p);
      return signed'({{(SUM_W-PIX_W){1'b0}}, p});
   endfunction

   function automatic logic [PIX_W-1:0] abs_sat(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] mag;
      mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      return (mag > SUM_W'(SAT_MAX)) ? SAT_MAX : mag[PIX_W-1:0];
   endfunction

endpackage

[hw/rtl/lpe_fifo.sv]
// lpe_fifo: small register-based queue with count, used between front and back
// and in front of the result port. Depends on no package.
module lpe_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [DATA_W-1:0]            push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [DATA_W-1:0]            pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/lpe_front.sv]
// lpe_front: raster position counters; tags each accepted pixel with its line store
// address, centre position, emit and last flags. Depends on lpe_pkg.
module lpe_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 restart,
   input  logic [lpe_pkg::WIDTH_REG_W-1:0]      frame_width,
   input  logic [lpe_pkg::HEIGHT_REG_W-1:0]     frame_height,
   input  logic                                 accept,
   input  logic [lpe_pkg::PIX_W-1:0]            pixel,
   output lpe_pkg::lpe_item_type                item,
   output logic [$clog2(MAX_WIDTH)-1:0]         addr
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CNT_W = CW + 1;
   localparam int RW    = lpe_pkg::ROW_W;

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CNT_W-1:0] width_eff;
   logic [RW-1:0]    height_eff;
   logic [31:0]      width_wide;
   logic             col_end, row_end;
   logic [CW+9:0]    col_prev;

   // clamp width to 3..MAX_WIDTH and height to at least 3
   always_comb begin
      width_wide = 32'(frame_width);
      if (width_wide < 32'(lpe_pkg::MIN_DIM)) begin
         width_eff = CNT_W'(lpe_pkg::MIN_DIM);
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         width_eff = CNT_W'(MAX_WIDTH);
      end else begin
         width_eff = CNT_W'(frame_width);
      end
      height_eff = (frame_height < RW'(lpe_pkg::MIN_DIM)) ? RW'(lpe_pkg::MIN_DIM)
                                                         : frame_height;
   end

   assign col_end  = (CNT_W'(col_ff) == width_eff - CNT_W'(1));
   assign row_end  = (row_ff == height_eff - RW'(1));
   assign col_prev = {10'b0, col_ff - CW'(1)};

   always_comb begin
      item.pixel      = pixel;
      item.center_col = col_prev[lpe_pkg::COL_OUT_W-1:0];
      item.center_row = row_ff - RW'(1);
      item.emit       = (col_ff >= CW'(2)) && (row_ff >= RW'(2));
      item.last       = col_end && row_end;
      addr            = col_ff;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> (col_ff == '0 && row_ff == '0))
      else $error("position counters not cleared after register write");

   a_last_is_interior: assert property (@(posedge clock) disable iff (reset)
      (accept && item.last) |-> item.emit)
      else $error("frame end marked on a border pixel");

endmodule

[hw/rtl/lpe_back.sv]
// lpe_back: line stores, 3x3 window and the two Laplacian masks, as a pipeline of line
// store read and mask sums, with credit toward the result queue. Depends on lpe_pkg.
module lpe_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int OUT_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 mid_empty,
   output logic                                 mid_pop,
   input  lpe_pkg::lpe_item_type                mid_item,
   input  logic [$clog2(MAX_WIDTH)-1:0]         mid_addr,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]       out_count,
   output logic                                 res_push,
   output lpe_pkg::lpe_result_type              res_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int OC_W  = $clog2(OUT_DEPTH+1);
   localparam int OCC_W = OC_W + 2;
   localparam int PW    = lpe_pkg::PIX_W;
   localparam int SW    = lpe_pkg::SUM_W;

   // line stores: a holds the line above, b two lines above
   logic [PW-1:0] store_a [MAX_WIDTH];
   logic [PW-1:0] store_b [MAX_WIDTH];

   logic [PW-1:0] rd_a_ff, rd_b_ff;

   logic                   s1_v_ff;
   lpe_pkg::lpe_item_type  s1_item_ff;
   logic [CW-1:0]          s1_addr_ff;

   logic                   s2_v_ff;
   lpe_pkg::lpe_item_type  s2_item_ff;
   logic signed [SW-1:0]   s2_four_ff, s2_four_in;
   logic signed [SW-1:0]   s2_eight_ff, s2_eight_in;

   logic [PW-1:0] win_lt_ff, win_lm_ff, win_lb_ff;
   logic [PW-1:0] win_mt_ff, win_mm_ff, win_mb_ff;

   logic [OCC_W-1:0] occupancy;
   logic [PW-1:0]    top, mid, bot;

   // issue only when the result queue has room for everything in flight
   assign occupancy = OCC_W'(out_count) + OCC_W'(s1_v_ff) + OCC_W'(s2_v_ff);
   assign mid_pop   = !mid_empty && (occupancy < OCC_W'(OUT_DEPTH));

   assign top = rd_b_ff;
   assign mid = rd_a_ff;
   assign bot = s1_item_ff.pixel;

   always_comb begin
      s2_four_in  = (lpe_pkg::ext_pix(win_mm_ff) <<< 2)
                    - lpe_pkg::ext_pix(win_mt_ff) - lpe_pkg::ext_pix(win_mb_ff)
                    - lpe_pkg::ext_pix(win_lm_ff) - lpe_pkg::ext_pix(mid);
      s2_eight_in = lpe_pkg::ext_pix(win_lt_ff) + lpe_pkg::ext_pix(win_lm_ff)
                    + lpe_pkg::ext_pix(win_lb_ff) + lpe_pkg::ext_pix(win_mt_ff)
                    + lpe_pkg::ext_pix(win_mb_ff) + lpe_pkg::ext_pix(top)
                    + lpe_pkg::ext_pix(mid) + lpe_pkg::ext_pix(bot)
                    - (lpe_pkg::ext_pix(win_mm_ff) <<< 3);
   end

   // read on issue, write back in the next cycle at the same column
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         rd_a_ff <= store_a[mid_addr];
         rd_b_ff <= store_b[mid_addr];
      end
      if (s1_v_ff) begin
         store_a[s1_addr_ff] <= bot;
         store_b[s1_addr_ff] <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         win_lt_ff <= '0;
         win_lm_ff <= '0;
         win_lb_ff <= '0;
         win_mt_ff <= '0;
         win_mm_ff <= '0;
         win_mb_ff <= '0;
      end else begin
         s1_v_ff <= mid_pop;
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            win_lt_ff <= win_mt_ff;
            win_lm_ff <= win_mm_ff;
            win_lb_ff <= win_mb_ff;
            win_mt_ff <= top;
            win_mm_ff <= mid;
            win_mb_ff <= bot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_item_ff <= mid_item;
         s1_addr_ff <= mid_addr;
      end
      if (s1_v_ff) begin
         s2_item_ff  <= s1_item_ff;
         s2_four_ff  <= s2_four_in;
         s2_eight_ff <= s2_eight_in;
      end
   end

   always_comb begin
      res_push            = s2_v_ff && s2_item_ff.emit;
      res_data.edge_four  = lpe_pkg::abs_sat(s2_four_ff);
      res_data.edge_eight = lpe_pkg::abs_sat(s2_eight_ff);
      res_data.center_col = s2_item_ff.center_col;
      res_data.center_row = s2_item_ff.center_row;
      res_data.frame_last = s2_item_ff.last;
   end

   // border pixels of the first lines may see unwritten line store entries; check interior only
   a_four_range: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_item_ff.emit) |-> (s2_four_ff <= 1020 && s2_four_ff >= -1020))
      else $error("4-neighbour sum out of range");

endmodule

[hw/rtl/laplacian_edge_3x3.sv]
// laplacian_edge_3x3: top level of the streaming 3x3 Laplacian edge filter.
// Holds the configuration registers and ties front, back and the queues together;
// depends on lpe_pkg, lpe_fifo, lpe_front and lpe_back.
//
//   channel  ports                         handshake
//   -------  ----------------------------  ------------------------------------
//   input    req_pixel                     accepted when req_push && !req_full
//   result   rsp_edge_*, rsp_center_*,     taken when rsp_pop && !rsp_empty
//            rsp_frame_last
//   config   csr_paddr, csr_pwdata, ...    written when psel, penable, pwrite
//
// One pixel per cycle sustained while the result side keeps up; a result becomes visible
// once its pixel has passed the front queue, line store read, mask sums, then the result queue.
// The line store read port, used once per pixel, sets the one-pixel-per-cycle rate.
// Reset is synchronous: counters clear, registers load 640 by 480, line stores keep
// their contents and need no clearing pass.
// A stalled result side fills the four-entry result queue; the back end then holds
// issue, the two-entry front queue fills and req_full rises.
module laplacian_edge_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [lpe_pkg::PIX_W-1:0]            req_pixel,

   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [lpe_pkg::PIX_W-1:0]            rsp_edge_four,
   output logic [lpe_pkg::PIX_W-1:0]            rsp_edge_eight,
   output logic [lpe_pkg::COL_OUT_W-1:0]        rsp_center_col,
   output logic [lpe_pkg::ROW_W-1:0]            rsp_center_row,
   output logic                                 rsp_frame_last,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lpe_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [lpe_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [lpe_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int ITEM_W    = $bits(lpe_pkg::lpe_item_type);
   localparam int MID_W     = ITEM_W + CW;
   localparam int RES_W     = $bits(lpe_pkg::lpe_result_type);
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;
   localparam int OC_W      = $clog2(OUT_DEPTH+1);

   // configuration registers
   logic [lpe_pkg::WIDTH_REG_W-1:0]  frame_width_ff, frame_width_in;
   logic [lpe_pkg::HEIGHT_REG_W-1:0] frame_height_ff, frame_height_in;
   logic                             csr_write;
   logic                             reg_index;

   // front to back
   logic                  req_accept;
   lpe_pkg::lpe_item_type front_item;
   logic [CW-1:0]         front_addr;
   logic [MID_W-1:0]      mid_push_data, mid_pop_data;
   logic                  mid_full, mid_empty, mid_pop;
   lpe_pkg::lpe_item_type mid_item;
   logic [CW-1:0]         mid_addr;

   // back to result queue
   logic                    res_push, res_full;
   lpe_pkg::lpe_result_type res_data, rsp_data;
   logic [RES_W-1:0]        rsp_bits;
   logic [OC_W-1:0]         out_count;

   // ---------------------------------------------------------------------
   // Configuration port: zero wait states, word index from the address
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (reg_index)
            lpe_pkg::REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[lpe_pkg::WIDTH_REG_W-1:0];
            lpe_pkg::REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[lpe_pkg::HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         lpe_pkg::REG_FRAME_WIDTH:  csr_prdata = lpe_pkg::CSR_DATA_W'(frame_width_ff);
         lpe_pkg::REG_FRAME_HEIGHT: csr_prdata = lpe_pkg::CSR_DATA_W'(frame_height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lpe_pkg::WIDTH_RESET;
         frame_height_ff <= lpe_pkg::HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front: classify each accepted transaction; any register write restarts
   // the frame at the next pixel
   // ---------------------------------------------------------------------
   assign req_full   = mid_full;
   assign req_accept = req_push && !mid_full;

   lpe_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .accept       (req_accept),
      .pixel        (req_pixel),
      .item         (front_item),
      .addr         (front_addr)
   );

   assign mid_push_data = {front_addr, front_item};

   // Decouple: a short queue lets front and back stall independently
   lpe_fifo #(
      .DATA_W (MID_W),
      .DEPTH  (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty),
      .count     ()
   );

   assign mid_item = lpe_pkg::lpe_item_type'(mid_pop_data[ITEM_W-1:0]);
   assign mid_addr = mid_pop_data[MID_W-1:ITEM_W];

   // ---------------------------------------------------------------------
   // Back: line stores, window and mask arithmetic
   // ---------------------------------------------------------------------
   lpe_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_item  (mid_item),
      .mid_addr  (mid_addr),
      .out_count (out_count),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Result queue: holds finished transactions while the consumer stalls
   lpe_fifo #(
      .DATA_W (RES_W),
      .DEPTH  (OUT_DEPTH)
   ) u_res_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_data       = lpe_pkg::lpe_result_type'(rsp_bits);
   assign rsp_edge_four  = rsp_data.edge_four;
   assign rsp_edge_eight = rsp_data.edge_eight;
   assign rsp_center_col = rsp_data.center_col;
   assign rsp_center_row = rsp_data.center_row;
   assign rsp_frame_last = rsp_data.frame_last;

   // the back end's credit check must never let a result meet a full queue
   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result dropped at full result queue");

endmodule

[tb/laplacian_edge_3x3_test.sv]
// laplacian_edge_3x3_test: self-checking testbench of the streaming 3x3 Laplacian edge filter.
// Drives pixels, configures frame size over the register port and checks every edge result
// against a cycle-free predictor kept here; depends on lpe_pkg and laplacian_edge_3x3.
module laplacian_edge_3x3_test;

   localparam int MAX_LINE      = 1024;
   localparam int RANDOM_ITEMS  = 750;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT   = 2000;   // cycles with no transaction anywhere
   localparam int PRINT_LIMIT   = 30;

   // byte addresses of the two frame-size registers
   localparam logic [lpe_pkg::CSR_ADDR_W-1:0] WIDTH_ADDR  = {lpe_pkg::REG_FRAME_WIDTH, 2'b00};
   localparam logic [lpe_pkg::CSR_ADDR_W-1:0] HEIGHT_ADDR = {lpe_pkg::REG_FRAME_HEIGHT, 2'b00};

   logic                           clock;
   logic                           reset;
   logic                           req_push;
   logic                           req_full;
   logic [lpe_pkg::PIX_W-1:0]      req_pixel;
   logic                           rsp_empty;
   logic                           rsp_pop;
   logic [lpe_pkg::PIX_W-1:0]      rsp_edge_four;
   logic [lpe_pkg::PIX_W-1:0]      rsp_edge_eight;
   logic [lpe_pkg::COL_OUT_W-1:0]  rsp_center_col;
   logic [lpe_pkg::ROW_W-1:0]      rsp_center_row;
   logic                           rsp_frame_last;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [lpe_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lpe_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lpe_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   laplacian_edge_3x3 #(.MAX_WIDTH(MAX_LINE)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel      (req_pixel),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_edge_four  (rsp_edge_four),
      .rsp_edge_eight (rsp_edge_eight),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: frame-size registers, the two previous lines, the last two window
   // columns and the position of the next pixel.
   // ---------------------------------------------------------------------------------------
   logic [lpe_pkg::WIDTH_REG_W-1:0]  width_setting;
   logic [lpe_pkg::HEIGHT_REG_W-1:0] height_setting;
   logic [lpe_pkg::PIX_W-1:0]        row_above [MAX_LINE];
   logic [lpe_pkg::PIX_W-1:0]        row_two_above [MAX_LINE];
   int                               window_px [6];   // left top/mid/bot, then middle top/mid/bot
   int unsigned                      next_col;
   int unsigned                      next_row;

   lpe_pkg::lpe_result_type          expected_edges [$];
   lpe_pkg::lpe_result_type          oldest_edge;

   int unsigned                      error_count;
   int unsigned                      idle_cycles;
   bit                               src_idle_on;
   bit                               sink_idle_on;
   int unsigned                      sink_hold;       // long hold-off requested by the pressure test
   int unsigned                      sink_gap;

   // ---------------------------------------------------------------------------------------
   // Clock: period 4.
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   function automatic logic [lpe_pkg::PIX_W-1:0] clip_magnitude(input int v);
      if (v < 0) v = -v;
      if (v > 255) v = 255;
      return v[lpe_pkg::PIX_W-1:0];
   endfunction

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(width_setting);
      if (w < lpe_pkg::MIN_DIM) w = lpe_pkg::MIN_DIM;
      if (w > MAX_LINE) w = MAX_LINE;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = 32'(height_setting);
      if (h < lpe_pkg::MIN_DIM) h = lpe_pkg::MIN_DIM;
      return h;
   endfunction

   // Advance the predictor by one accepted pixel; queue the edge result it produces, if any.
   task automatic predict_edges(input logic [lpe_pkg::PIX_W-1:0] px);
      int unsigned             w, h, c, r, ci;
      int                      top, mid, bot, four, eight;
      lpe_pkg::lpe_result_type res;
      w = active_width();
      h = active_height();
      c = next_col;
      r = next_row;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      ci = c % MAX_LINE;
      top = int'(row_two_above[ci]);
      mid = int'(row_above[ci]);
      bot = int'(px);
      row_two_above[ci] = lpe_pkg::PIX_W'(mid);
      row_above[ci] = px;
      // interior centre: the window now spans columns c-2..c of rows r-2..r
      if (c >= 2 && r >= 2) begin
         four  = 4 * window_px[4] - window_px[3] - window_px[5] - window_px[1] - mid;
         eight = window_px[0] + window_px[1] + window_px[2] + window_px[3] + window_px[5]
                 + top + mid + bot - 8 * window_px[4];
         res.edge_four  = clip_magnitude(four);
         res.edge_eight = clip_magnitude(eight);
         res.center_col = lpe_pkg::COL_OUT_W'(c - 1);
         res.center_row = lpe_pkg::ROW_W'(r - 1);
         res.frame_last = (c == w - 1) && (r == h - 1);
         expected_edges.push_back(res);
      end
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = bot;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r;
   endtask

   // ---------------------------------------------------------------------------------------
   // Sender: one pixel transaction, with a random idle burst ahead of it when enabled.
   // push stays high from one pixel to the next and is driven only at falling edges.
   // ---------------------------------------------------------------------------------------
   task automatic send_pixel(input logic [lpe_pkg::PIX_W-1:0] px);
      int unsigned gap;
      gap = 0;
      if (src_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push  <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_edges(px);
   endtask

   function automatic logic [lpe_pkg::PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       return lpe_pkg::PIX_W'($urandom_range(100, 140));   // smooth area
         default: return lpe_pkg::PIX_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Register port: setup cycle, then access cycle; the write lands when pready is high.
   // ---------------------------------------------------------------------------------------
   task automatic csr_write(input logic [lpe_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [lpe_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // mirror the write: mask to the register width and restart the frame
      if (addr == WIDTH_ADDR) begin
         width_setting = data[lpe_pkg::WIDTH_REG_W-1:0];
      end else begin
         height_setting = data[lpe_pkg::HEIGHT_REG_W-1:0];
      end
      next_col = 0;
      next_row = 0;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input logic [lpe_pkg::CSR_ADDR_W-1:0] addr);
      logic [lpe_pkg::CSR_DATA_W-1:0] want;
      want = (addr == WIDTH_ADDR) ? lpe_pkg::CSR_DATA_W'(width_setting)
                                  : lpe_pkg::CSR_DATA_W'(height_setting);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         report_error($sformatf("register at %0d reads %0h, want %0h", addr, csr_prdata, want));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drop push and wait until every expected result is back, then let border pixels that
   // give no result drain out of the pipeline.
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [lpe_pkg::CSR_DATA_W-1:0] w,
                            input logic [lpe_pkg::CSR_DATA_W-1:0] h);
      settle();
      csr_write(WIDTH_ADDR, w);
      csr_write(HEIGHT_ADDR, h);
      csr_check(WIDTH_ADDR);
      csr_check(HEIGHT_ADDR);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------
   task automatic test_reset_values();
      csr_check(WIDTH_ADDR);
      csr_check(HEIGHT_ADDR);
   endtask

   // Smallest frame with a bright dot, then its negative straight after (counter wrap at the
   // end of a frame), then a cut-off frame that the next register write must restart.
   task automatic test_directed();
      int i;
      configure(3, 3);
      for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00);
      for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF);
      for (i = 0; i < 3; i++) send_pixel(8'h80 + lpe_pkg::PIX_W'(i));
   endtask

   // Sizes below the minimum act as three; a width beyond the line stores acts as the maximum,
   // so a short burst there stays on the top border and gives no result.
   task automatic test_size_extremes();
      int i;
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      configure(0, 0);
      for (i = 0; i < 11; i++) send_pixel(pick_pixel());
      configure(2, 2);
      for (i = 0; i < 9; i++) send_pixel(pick_pixel());
      configure(32'd2047, 1);
      for (i = 0; i < 40; i++) send_pixel(pick_pixel());
   endtask

   // Mostly small frames, whole or doubled, with some frames cut short by a register write.
   task automatic test_random_frames();
      int unsigned                    sent, w, h, fw, fh, count, i;
      logic [lpe_pkg::CSR_DATA_W-1:0] wword, hword;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 10);
         h = $urandom_range(0, 6);
         wword = w;
         hword = h;
         if ($urandom_range(0, 3) == 0) begin
            // junk above the register width must be dropped
            wword[lpe_pkg::CSR_DATA_W-1:lpe_pkg::WIDTH_REG_W]  = 21'($urandom);
            hword[lpe_pkg::CSR_DATA_W-1:lpe_pkg::HEIGHT_REG_W] = 16'($urandom);
         end
         src_idle_on  = ($urandom_range(0, 2) != 0);
         sink_idle_on = ($urandom_range(0, 2) != 0);
         configure(wword, hword);
         fw = active_width();
         fh = active_height();
         case ($urandom_range(0, 3))
            0:       count = $urandom_range(1, fw * fh - 1);
            1:       count = 2 * fw * fh;
            default: count = fw * fh;
         endcase
         if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
         for (i = 0; i < count; i++) send_pixel(pick_pixel());
         sent += count;
      end
   endtask

   // Hold the result side off while pixels keep coming, so the queues fill and req_full rises.
   task automatic test_backpressure();
      int i;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      configure(5, 20);
      sink_hold = 120;
      for (i = 0; i < 60; i++) send_pixel(pick_pixel());
   endtask

   // Narrowest frame, back to back and without idling on either side, across two frame wraps.
   task automatic test_steady_stream();
      int i;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      configure(1, 8);
      for (i = 0; i < 2 * 3 * 8 + 6; i++) send_pixel(lpe_pkg::PIX_W'($urandom));
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver: pop is driven at the falling edge; a long hold-off wins over random bursts.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold = sink_hold - 1;
         rsp_pop <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap = sink_gap - 1;
         rsp_pop <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
         sink_gap = $urandom_range(0, 6);   // idle in this cycle and while sink_gap counts down
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Compare each popped result, field by field, with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_edges.size() == 0) begin
            report_error($sformatf("result with nothing expected at col %0d row %0d",
                                   rsp_center_col, rsp_center_row));
         end else begin
            oldest_edge = expected_edges.pop_front();
            if (rsp_edge_four !== oldest_edge.edge_four ||
                rsp_edge_eight !== oldest_edge.edge_eight ||
                rsp_center_col !== oldest_edge.center_col ||
                rsp_center_row !== oldest_edge.center_row ||
                rsp_frame_last !== oldest_edge.frame_last) begin
               report_error($sformatf(
                  "got four %0d eight %0d col %0d row %0d last %0b, want %0d %0d %0d %0d %0b",
                  rsp_edge_four, rsp_edge_eight, rsp_center_col, rsp_center_row,
                  rsp_frame_last, oldest_edge.edge_four, oldest_edge.edge_eight,
                  oldest_edge.center_col, oldest_edge.center_row, oldest_edge.frame_last));
            end
         end
      end
   end

   // Watchdog: end the run once no transaction of any kind has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("laplacian_edge_3x3_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_pixel      = '0;
      rsp_pop        = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      error_count    = 0;
      idle_cycles    = 0;
      src_idle_on    = 1'b1;
      sink_idle_on   = 1'b1;
      sink_hold      = 0;
      sink_gap       = 0;
      width_setting  = lpe_pkg::WIDTH_RESET;
      height_setting = lpe_pkg::HEIGHT_RESET;
      next_col       = 0;
      next_row       = 0;
      foreach (window_px[i]) window_px[i] = 0;
      foreach (row_above[i]) begin
         row_above[i]     = '0;
         row_two_above[i] = '0;
      end

      // hold reset, then release it between edges
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      test_size_extremes();
      test_random_frames();
      test_backpressure();
      test_steady_stream();
      settle();

      if (error_count == 0) begin
         $display("laplacian_edge_3x3_test passed");
      end else begin
         $display("laplacian_edge_3x3_test failed");
      end
      $finish;
   end

endmodule
